[src/tempo_map_tick_to_ms_assert.svh]
// assertion macros used by the tempo map top module
`ifndef TEMPO_MAP_TICK_TO_MS_ASSERT_SVH
`define TEMPO_MAP_TICK_TO_MS_ASSERT_SVH

// plain check of a property sampled on clk, off during reset
`define TMT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tempo map assertion failed");

// check of an implication whose consequence is checked in the cycle after its condition
`define TMT_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("tempo map assertion failed");

`endif

[src/tmt_pkg.sv]
// shared types and constants of the tempo map
package tmt_pkg;

	localparam int TableDepthDefault = 256;
	localparam int TimeW = 28;
	localparam int TempoW = 24;
	localparam int DefW = 20;
	localparam int SumW = TimeW + TempoW;
	localparam int DivW = SumW + 1;
	localparam int CountOutW = 9;
	// width of the rounded sum divided by 8 while below the saturation limit
	localparam int ShrW = 39;
	localparam int RecipW = 40;
	localparam logic [DefW-1:0] DefaultReset = 20'd1250;
	localparam logic [DivW-1:0] RoundBias = 53'd500;
	// ceil(2^46 / 125), exact quotient for any 39-bit dividend
	localparam logic [RecipW-1:0] MsRecip = 40'd562949953422;
	// 1000 * 2^32, first rounded sum whose milliseconds no longer fit 32 bits
	localparam logic [DivW-1:0] SatLimit = 53'd4294967296000;

	typedef enum logic [1:0] {
		KIND_INS = 2'd0,
		KIND_REM = 2'd1,
		KIND_QRY = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SAT  = 2'd2,
		STAT_RSV  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_SHL  = 2'd2,
		OP_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [TimeW-1:0]  key;
		logic [TempoW-1:0] tempo;
	} cell_ctl_t;

endpackage

[src/tmt_cell.sv]
// one table entry cell of the sorted tempo chain
module tmt_cell (
	input  logic                      clk,
	input  tmt_pkg::cell_ctl_t        ctl,
	input  logic                      valid,
	input  logic                      at_end,
	input  logic                      prev_gt,
	input  logic [tmt_pkg::TimeW-1:0] prev_time,
	input  logic [tmt_pkg::TempoW-1:0] prev_tempo,
	input  logic [tmt_pkg::TimeW-1:0] next_time,
	input  logic [tmt_pkg::TempoW-1:0] next_tempo,
	output logic [tmt_pkg::TimeW-1:0] time_q,
	output logic [tmt_pkg::TempoW-1:0] tempo_q,
	output logic                      gt,
	output logic                      ge
);
	import tmt_pkg::*;

	assign gt = valid && (time_q > ctl.key);
	assign ge = valid && (time_q >= ctl.key);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (prev_gt) begin
					time_q  <= prev_time;
					tempo_q <= prev_tempo;
				end else if (gt || at_end) begin
					time_q  <= ctl.key;
					tempo_q <= ctl.tempo;
				end
			end
			OP_SHL: begin
				if (ge) begin
					time_q  <= next_time;
					tempo_q <= next_tempo;
				end
			end
			OP_ROT: begin
				time_q  <= next_time;
				tempo_q <= next_tempo;
			end
			default: begin
			end
		endcase
	end
endmodule

[src/tmt_div.sv]
// reciprocal-multiply divide by 1000 for the microsecond to millisecond step
module tmt_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tmt_pkg::DivW-1:0] dividend,
	output logic                     busy,
	output logic                     done,
	output logic [tmt_pkg::DivW-1:0] quotient
);
	import tmt_pkg::*;

	localparam int LoW = 20;
	localparam int HiW = ShrW - LoW;
	localparam int PloW = LoW + RecipW;
	localparam int PhiW = HiW + RecipW;
	localparam int ProdW = PhiW + LoW + 1;
	localparam int QShift = ShrW + 7;

	logic [ShrW-1:0]  y_q;
	logic             sat_q;
	logic [PloW-1:0]  plo_q;
	logic [PhiW-1:0]  phi_q;
	logic [DivW-1:0]  quo_q;
	logic             busy_q;
	logic             phase_q;
	logic             done_q;
	logic [ProdW-1:0] prod;

	// x / 1000 = (x / 8) / 125, the second step as a multiply by the reciprocal
	assign prod = ProdW'(plo_q) + {1'b0, phi_q, {LoW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= 1'b1;
				if (phase_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q   <= dividend[ShrW+2:3];
			sat_q <= (dividend >= SatLimit);
		end else if (busy_q && !phase_q) begin
			plo_q <= PloW'(y_q[LoW-1:0]) * PloW'(MsRecip);
			phi_q <= PhiW'(y_q[ShrW-1:LoW]) * PhiW'(MsRecip);
		end else if (busy_q) begin
			quo_q <= sat_q ? '1 : DivW'(prod[ProdW-1:QShift]);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
endmodule

[src/tempo_map_tick_to_ms.sv]
// tempo map: sorted tempo table in a chain of cells, tick interval to milliseconds
// One item is taken at a time. An insert goes from the transfer through S_INS to
// S_DONE: every cell compares its time with the new one and the later entries move
// one cell up together. A remove stays in S_REM while an entry carries the given
// time; each step drops one of them by moving the cells above it down. In a query
// the whole chain is rotated once through cell 0, and each entry that passes adds tempo
// times its overlap with the interval through a three stage overlap, multiply and
// accumulate pipeline; then the rounded sum is divided by 1000 by a shift and a
// multiply by the reciprocal, a compare with 1000 * 2^32 flagging saturation. The
// result register frees the input side as soon as the result is loaded, so the next
// transfer can be taken while the last result still waits. The table has no clearing
// pass.
module tempo_map_tick_to_ms #(
	parameter int TABLE_DEPTH = tmt_pkg::TableDepthDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// entry_time[27:0], usec_per_tick[51:28], start_tick[79:52], end_tick[107:80]
	input  logic [111:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// elapsed_ms[31:0], entry_count[40:32]
	output logic [47:0]  m_tdata,
	// status[1:0]
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tmt_pkg::*;

	`include "tempo_map_tick_to_ms_assert.svh"

	localparam int CntW = $clog2(TABLE_DEPTH + 1);
	localparam int StepW = $clog2(TABLE_DEPTH + 4);
	localparam logic [StepW-1:0] LastRot = StepW'(TABLE_DEPTH);
	localparam logic [StepW-1:0] DivGo = StepW'(TABLE_DEPTH + 3);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_REM,
		S_QRY,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   count_q;
	logic [StepW-1:0]  step_q;
	logic [DefW-1:0]   def_tempo_q;
	logic [TimeW-1:0]  key_q;
	logic [TempoW-1:0] new_tempo_q;
	logic [TimeW-1:0]  start_q;
	logic [TimeW-1:0]  end_q;
	logic [31:0]       ms_q;
	status_t           status_q;
	logic              out_valid_q;
	logic [31:0]       out_ms_q;
	logic [CountOutW-1:0] out_cnt_q;
	status_t           out_status_q;

	// query pipeline
	logic [TimeW-1:0]  lo_q;
	logic [TempoW-1:0] seg_tempo_q;
	logic [TimeW-1:0]  len_s1;
	logic [TempoW-1:0] tempo_s1;
	logic              vld_s1;
	logic [SumW-1:0]   prod_s2;
	logic              vld_s2;
	logic [SumW-1:0]   acc_q;

	logic              in_xfer;
	logic              full;
	logic              hit;
	logic              head_vld;
	logic              tail;
	logic [TimeW-1:0]  hi;
	logic [TimeW-1:0]  lo;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [DivW-1:0]   div_q;
	logic              out_free;
	cell_ctl_t         ctl;

	logic [TimeW-1:0]  cell_time [TABLE_DEPTH];
	logic [TempoW-1:0] cell_tempo [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] cell_gt;
	logic [TABLE_DEPTH-1:0] cell_ge;
	logic [TABLE_DEPTH-1:0] cell_eq;

	// configuration port, one register at byte address 0
	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {12'd0, def_tempo_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_tempo_q <= DefaultReset;
		end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
			def_tempo_q <= pwdata[DefW-1:0];
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer = s_tvalid && s_tready;
	assign full = (count_q == CntW'(TABLE_DEPTH));
	assign hit = |cell_eq;
	assign out_free = !out_valid_q || m_tready;

	// cell commands
	always_comb begin
		ctl.key = key_q;
		ctl.tempo = new_tempo_q;
		ctl.op = OP_HOLD;
		case (state_q)
			S_INS: ctl.op = full ? OP_HOLD : OP_INS;
			S_REM: ctl.op = hit ? OP_SHL : OP_HOLD;
			S_QRY: ctl.op = (step_q < LastRot) ? OP_ROT : OP_HOLD;
			default: ctl.op = OP_HOLD;
		endcase
	end

	// the chain; the top cell wraps to cell 0 so a full rotation restores order
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic vld;
		logic last;
		assign vld = CntW'(i) < count_q;
		assign last = CntW'(i) == count_q;
		assign cell_eq[i] = cell_ge[i] && !cell_gt[i];
		tmt_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (vld),
			.at_end     (last),
			.prev_gt    ((i == 0) ? 1'b0 : cell_gt[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.prev_time  (cell_time[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.prev_tempo (cell_tempo[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
			.next_time  (cell_time[(i + 1) % TABLE_DEPTH]),
			.next_tempo (cell_tempo[(i + 1) % TABLE_DEPTH]),
			.time_q     (cell_time[i]),
			.tempo_q    (cell_tempo[i]),
			.gt         (cell_gt[i]),
			.ge         (cell_ge[i])
		);
	end

	// overlap of the current tempo segment with the query interval
	always_comb begin
		head_vld = (state_q == S_QRY) && (step_q < LastRot)
			&& ({1'b0, step_q} < (StepW + 1)'(count_q));
		tail = (state_q == S_QRY) && (step_q == LastRot);
		hi = end_q;
		if (!tail && (cell_time[0] < end_q)) begin
			hi = cell_time[0];
		end
		lo = (lo_q > start_q) ? lo_q : start_q;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lo_q <= '0;
			seg_tempo_q <= TempoW'(def_tempo_q);
		end else if (head_vld) begin
			lo_q <= cell_time[0];
			seg_tempo_q <= cell_tempo[0];
		end
		len_s1 <= (hi > lo) ? hi - lo : '0;
		tempo_s1 <= seg_tempo_q;
		prod_s2 <= SumW'(tempo_s1) * SumW'(len_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			vld_s1 <= head_vld || tail;
			vld_s2 <= vld_s1;
			if (in_xfer) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + prod_s2;
			end
		end
	end

	assign div_start = (state_q == S_QRY) && (step_q == DivGo);

	tmt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DivW'(acc_q) + RoundBias),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q <= '0;
			status_q <= STAT_OK;
			ms_q <= '0;
			out_valid_q <= 1'b0;
			out_ms_q <= '0;
			out_cnt_q <= '0;
			out_status_q <= STAT_OK;
			key_q <= '0;
			new_tempo_q <= '0;
			start_q <= '0;
			end_q <= '0;
		end else begin
			// a result loaded in the same cycle keeps the valid flag set
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						key_q <= s_tdata[27:0];
						new_tempo_q <= s_tdata[51:28];
						start_q <= s_tdata[79:52];
						end_q <= s_tdata[107:80];
						status_q <= STAT_OK;
						ms_q <= '0;
						step_q <= '0;
						case (kind_t'(s_tuser))
							KIND_INS: state_q <= S_INS;
							KIND_REM: state_q <= S_REM;
							KIND_QRY: state_q <= S_QRY;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_INS: begin
					if (full) begin
						status_q <= STAT_FULL;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_REM: begin
					if (hit) begin
						count_q <= count_q - 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_QRY: begin
					step_q <= step_q + 1'b1;
					if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (|div_q[DivW-1:32]) begin
							ms_q <= 32'hFFFF_FFFF;
							status_q <= STAT_SAT;
						end else begin
							ms_q <= div_q[31:0];
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_ms_q <= ms_q;
						out_cnt_q <= CountOutW'(count_q);
						out_status_q <= status_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'd0, out_cnt_q, out_ms_q};
	assign m_tuser = out_status_q;

	`TMT_ASSERT(a_count_range, count_q <= CntW'(TABLE_DEPTH))
	`TMT_ASSERT(a_div_only_in_query, div_busy |-> (state_q == S_DIV))
	`TMT_ASSERT_NEXT(a_full_insert_keeps_count, (state_q == S_INS) && full, count_q == $past(count_q))
endmodule

[dv/testbench.sv]
// self-checking testbench of the tempo map tick to millisecond block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tmt_pkg::*;

	localparam int DEPTH = 256;
	localparam int CYCLE_LIMIT = 2000000;
	// allow headroom at the end for a query to pass through the whole table
	localparam int DRAIN_CYCLES = 400;
	localparam logic [2:0] ADDR_DEFAULT_TEMPO = 3'd0;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// entry_time[27:0], usec_per_tick[51:28], start_tick[79:52], end_tick[107:80]
	logic [111:0] s_tdata;
	// kind[1:0]
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// elapsed_ms[31:0], entry_count[40:32]
	logic [47:0]  m_tdata;
	// status[1:0]
	logic [1:0]   m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	tempo_map_tick_to_ms #(.TABLE_DEPTH(DEPTH)) dut (.*);

	// one tempo map result
	typedef struct packed {
		logic [31:0] ms;
		logic [8:0]  count;
		status_t     stat;
	} tempo_result_t;

	// predictor state: the sorted tempo table and the default tempo
	logic [TimeW-1:0]  tab_time [DEPTH];
	logic [TempoW-1:0] tab_tempo [DEPTH];
	int                tab_used;
	logic [DefW-1:0]   def_tempo;

	tempo_result_t pending_results[$];
	int  error_count;
	int  cycle_count;
	bit  idle_on;          // random gaps on both sides
	bit  hold_sink;        // receiver holds off for a long stretch
	int  hold_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// position of the last entry at or before t, -1 if none
	function automatic int last_at_or_before(input logic [TimeW-1:0] t);
		for (int i = tab_used - 1; i >= 0; i--)
			if (tab_time[i] <= t) return i;
		return -1;
	endfunction

	function automatic logic [63:0] tempo_of(input int pos);
		return (pos < 0) ? 64'(def_tempo) : 64'(tab_tempo[pos]);
	endfunction

	// advance the table model by one item and return the expected result
	function automatic tempo_result_t predict_tempo_map(input kind_t k,
			input logic [TimeW-1:0] et, input logic [TempoW-1:0] tp,
			input logic [TimeW-1:0] st, input logic [TimeW-1:0] en);
		tempo_result_t r;
		int pos, wr, p1, p2;
		logic [63:0] sum, ms;
		logic [TimeW-1:0] cur;
		r = '0;
		r.stat = STAT_OK;
		case (k)
			KIND_INS: begin
				if (tab_used >= DEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					pos = tab_used;
					while (pos > 0 && tab_time[pos-1] > et) begin
						tab_time[pos] = tab_time[pos-1];
						tab_tempo[pos] = tab_tempo[pos-1];
						pos--;
					end
					tab_time[pos] = et;
					tab_tempo[pos] = tp;
					tab_used++;
				end
			end
			KIND_REM: begin
				wr = 0;
				for (int rd = 0; rd < tab_used; rd++)
					if (tab_time[rd] != et) begin
						tab_time[wr] = tab_time[rd];
						tab_tempo[wr] = tab_tempo[rd];
						wr++;
					end
				tab_used = wr;
			end
			KIND_QRY: begin
				if (en > st) begin
					p1 = last_at_or_before(st);
					p2 = last_at_or_before(en);
					sum = 0;
					cur = st;
					for (int i = p1; i < p2; i++) begin
						sum += tempo_of(i) * 64'(tab_time[i+1] - cur);
						cur = tab_time[i+1];
					end
					sum += tempo_of(p2) * 64'(en - cur);
					ms = (sum + 64'd500) / 64'd1000;
					if (ms > 64'hFFFF_FFFF) begin
						r.ms = 32'hFFFF_FFFF;
						r.stat = STAT_SAT;
					end else begin
						r.ms = ms[31:0];
					end
				end
			end
			default: ;
		endcase
		r.count = 9'(tab_used);
		return r;
	endfunction

	// send one item, keeping the expectation in step with the transfer
	task automatic send_item(input kind_t k, input logic [TimeW-1:0] et,
			input logic [TempoW-1:0] tp, input logic [TimeW-1:0] st,
			input logic [TimeW-1:0] en);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= {4'b0, en, st, tp, et};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(predict_tempo_map(k, et, tp, st, en));
	endtask

	// wait until every result is in, then let the block settle
	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_tempo(input logic [DefW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_DEFAULT_TEMPO;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		def_tempo = v;
		// read back the register
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[DefW-1:0] !== v) report_mismatch("default tempo readback", prdata, v);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [TimeW-1:0] rand_time();
		case ($urandom_range(0, 3))
			0: return TimeW'($urandom_range(0, 40));
			1: return TimeW'($urandom_range(0, 2000));
			2: return TimeW'($urandom);
			default: return {TimeW{1'b1}} - TimeW'($urandom_range(0, 40));
		endcase
	endfunction

	function automatic logic [TempoW-1:0] rand_tempo();
		return ($urandom_range(0, 5) == 0) ? {TempoW{1'b1}} : TempoW'($urandom);
	endfunction

	// result checker
	always @(posedge clk) begin
		tempo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[31:0] !== want.ms)
					report_mismatch("elapsed_ms", m_tdata[31:0], want.ms);
				if (m_tdata[40:32] !== want.count)
					report_mismatch("entry_count", m_tdata[40:32], want.count);
				if (m_tuser !== want.stat)
					report_mismatch("status", m_tuser, want.stat);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_sink) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// corner values of the fields, every kind, empty and overflowing queries
	task automatic test_directed();
		send_item(KIND_QRY, 0, 0, 0, {TimeW{1'b1}});
		send_item(KIND_QRY, 0, 0, 100, 100);
		send_item(KIND_QRY, 0, 0, 200, 100);
		send_item(KIND_INS, 0, {TempoW{1'b1}}, 0, 0);
		send_item(KIND_INS, {TimeW{1'b1}}, 1, 0, 0);
		send_item(KIND_INS, 1000, 0, 0, 0);
		send_item(KIND_INS, 1000, 500, 0, 0);
		send_item(KIND_QRY, 0, 0, 0, {TimeW{1'b1}});
		send_item(KIND_QRY, 0, 0, 500, 3000);
		send_item(KIND_NOP, {TimeW{1'b1}}, {TempoW{1'b1}}, 0, 9);
		send_item(KIND_REM, 1000, 0, 0, 0);
		send_item(KIND_REM, 77, 0, 0, 0);
		send_item(KIND_QRY, 0, 0, 1, 2);
		send_item(KIND_REM, 0, 0, 0, 0);
		send_item(KIND_REM, {TimeW{1'b1}}, 0, 0, 0);
		drain();
	endtask

	// fill the table to overflow, then remove everything
	task automatic test_full_table();
		for (int i = 0; i < DEPTH + 3; i++)
			send_item(KIND_INS, TimeW'($urandom_range(0, 60)), rand_tempo(), 0, 0);
		send_item(KIND_QRY, 0, 0, 0, {TimeW{1'b1}});
		send_item(KIND_QRY, 0, 0, 5, 50);
		for (int t = 0; t <= 60; t++)
			send_item(KIND_REM, TimeW'(t), 0, 0, 0);
		drain();
	endtask

	// random mix: mostly inserts and queries, some removes of existing times
	task automatic test_random(input int n);
		kind_t k;
		logic [TimeW-1:0] et, st, en;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: k = KIND_INS;
				4, 5: k = KIND_REM;
				9: k = ($urandom_range(0, 1) != 0) ? KIND_NOP : KIND_QRY;
				default: k = KIND_QRY;
			endcase
			et = rand_time();
			if (k == KIND_REM && tab_used > 0 && $urandom_range(0, 2) != 0)
				et = tab_time[$urandom_range(0, tab_used - 1)];
			st = rand_time();
			en = ($urandom_range(0, 4) == 0) ? rand_time() : st + TimeW'($urandom_range(0, 5000));
			send_item(k, et, rand_tempo(), st, en);
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_back_pressure();
		hold_cycles = 0;
		hold_sink = 1'b1;
		fork
			begin
				for (int i = 0; i < 6; i++)
					send_item(KIND_INS, TimeW'($urandom_range(0, 99)), rand_tempo(), 0, 0);
			end
			begin
				while (hold_cycles < 300) @(posedge clk);
				hold_sink <= 1'b0;
			end
		join
		drain();
	endtask

	initial begin
		clk = 1'b0;
		error_count = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		hold_sink = 1'b0;
		hold_cycles = 0;
		def_tempo = DefaultReset;
		tab_used = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_NOP;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		write_default_tempo(20'd1);
		test_directed();
		write_default_tempo(20'd600000);
		test_full_table();
		test_back_pressure();
		write_default_tempo({DefW{1'b1}});
		test_random(200);
		drain();
		write_default_tempo(20'd0);
		test_random(100);
		drain();
		write_default_tempo(DefaultReset);
		test_random(150);
		// last part without idling
		idle_on = 1'b0;
		test_random(100);
		drain();

		if (pending_results.size() != 0)
			report_mismatch("missing results", 64'(pending_results.size()), 0);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
